### design/jsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, status codes and decode helpers for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  typedef enum logic [2:0] {
    ST_CONT   = 3'd0,
    ST_CLOSED = 3'd1,
    ST_BADESC = 3'd2,
    ST_BADHEX = 3'd3,
    ST_UNTERM = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'b001,
    MODE_ESCAPE = 3'b010,
    MODE_HEX    = 3'b100
  } mode_t;

  localparam logic [7:0]  CHR_QUOTE  = 8'h22;
  localparam logic [7:0]  CHR_BSLASH = 8'h5C;
  localparam logic [7:0]  CHR_SLASH  = 8'h2F;
  localparam logic [7:0]  CHR_U      = 8'h75;

  localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0]  UTF8_CONT  = 8'h80;
  localparam logic [7:0]  UTF8_MASK  = 8'h3F;
  localparam logic [15:0] CP_ONE_MAX = 16'h0080;
  localparam logic [15:0] CP_TWO_MAX = 16'h0800;

  // One unit of work handed from the front to the back.
  typedef struct packed {
    logic [15:0] data;     // plain byte in [7:0], or a code point
    logic        is_cp;    // data is a code point to be UTF-8 encoded
    logic        valid;    // carries a byte; otherwise a status flag only
    status_t     status;
  } job_t;

  // Hex digit value in [3:0], bit 4 set when the byte is no hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = {1'b0, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = {1'b0, 4'(c - 8'h37)};
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

  // Single-letter escapes; bit 8 set when the letter is not one of them.
  function automatic logic [8:0] escape_byte(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      CHR_QUOTE:  r = {1'b0, CHR_QUOTE};
      CHR_BSLASH: r = {1'b0, CHR_BSLASH};
      CHR_SLASH:  r = {1'b0, CHR_SLASH};
      8'h62:      r = 9'h008;
      8'h66:      r = 9'h00C;
      8'h6E:      r = 9'h00A;
      8'h72:      r = 9'h00D;
      8'h74:      r = 9'h009;
      default:    r = 9'h100;
    endcase
    return r;
  endfunction

endpackage

### design/json_string_unescape_utf8.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// JSON string body unescaper: escapes and \uXXXX to UTF-8 bytes.
//
//   channel  | handshake        | payload
//   ---------+------------------+-------------------------------------------
//   input    | push / full      | in_byte, text_ends
//   result   | pop / empty      | out_byte, byte_valid, status, last_of_run
//
// One input byte is taken per cycle while the job queue has room.
// The back end sends one result item per cycle while results are popped, so
// a \u escape that encodes to two or three UTF-8 bytes holds its job until
// its last byte is loaded. The output register loads from the queue head
// when empty or popped. Synchronous reset clears queue and output register.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8
  import jsu_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte,
  input  wire logic       text_ends,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic            byte_valid,
  output logic [2:0]      status,
  output logic            last_of_run
);

  job_t front_job, head_job;
  logic front_push, head_avail, head_take;

  jsu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (push && !full),
    .in_byte   (in_byte),
    .text_ends (text_ends),
    .job       (front_job),
    .job_push  (front_push)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (front_push),
    .wr_job (front_job),
    .take   (head_take),
    .rd_job (head_job),
    .full   (full),
    .avail  (head_avail)
  );

  jsu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job         (head_job),
    .job_avail   (head_avail),
    .job_take    (head_take),
    .pop         (pop),
    .empty       (empty),
    .out_byte    (out_byte),
    .byte_valid  (byte_valid),
    .status      (status),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire

### design/jsu_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_front
// Takes input bytes, tracks escape and \u state, and issues one job per
// byte that produces output. Silent bytes issue nothing.
// ----------------------------------------------------------------------------
module jsu_front
  import jsu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       take,
  input  wire logic [7:0] in_byte,
  input  wire logic       text_ends,
  output job_t            job,
  output logic            job_push
);

  mode_t       mode, mode_next;
  logic [1:0]  digits, digits_next;
  logic [15:0] cp, cp_next;
  logic [4:0]  hv;
  logic [8:0]  esc;

  assign hv  = hex_value(in_byte);
  assign esc = escape_byte(in_byte);

  always_comb begin
    mode_next   = mode;
    digits_next = digits;
    cp_next     = cp;
    job         = '{data: {8'h00, in_byte}, is_cp: 1'b0, valid: 1'b1, status: ST_CONT};
    job_push    = 1'b0;
    if (take) begin
      if (text_ends) begin
        job      = '{data: '0, is_cp: 1'b0, valid: 1'b0, status: ST_UNTERM};
        job_push = 1'b1;
        mode_next = MODE_NORMAL; digits_next = '0; cp_next = '0;
      end else begin
        case (mode)
          MODE_ESCAPE: begin
            mode_next = MODE_NORMAL; digits_next = '0; cp_next = '0;
            if (in_byte == CHR_U) begin
              mode_next = MODE_HEX;
            end else if (esc[8]) begin
              job      = '{data: '0, is_cp: 1'b0, valid: 1'b0, status: ST_BADESC};
              job_push = 1'b1;
            end else begin
              job.data = {8'h00, esc[7:0]};
              job_push = 1'b1;
            end
          end
          MODE_HEX: begin
            if (hv[4]) begin
              job      = '{data: '0, is_cp: 1'b0, valid: 1'b0, status: ST_BADHEX};
              job_push = 1'b1;
              mode_next = MODE_NORMAL; digits_next = '0; cp_next = '0;
            end else if (digits == 2'd3) begin
              job      = '{data: {cp[11:0], hv[3:0]}, is_cp: 1'b1, valid: 1'b1,
                           status: ST_CONT};
              job_push = 1'b1;
              mode_next = MODE_NORMAL; digits_next = '0; cp_next = '0;
            end else begin
              cp_next     = {cp[11:0], hv[3:0]};
              digits_next = digits + 2'd1;
            end
          end
          default: begin
            if (in_byte == CHR_QUOTE) begin
              job      = '{data: '0, is_cp: 1'b0, valid: 1'b0, status: ST_CLOSED};
              job_push = 1'b1;
              mode_next = MODE_NORMAL; digits_next = '0; cp_next = '0;
            end else if (in_byte == CHR_BSLASH) begin
              mode_next = MODE_ESCAPE;
            end else begin
              job_push = 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_NORMAL;
      digits <= '0;
      cp     <= '0;
    end else begin
      mode   <= mode_next;
      digits <= digits_next;
      cp     <= cp_next;
    end
  end

endmodule

`default_nettype wire

### design/jsu_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_queue
// Small job FIFO between the front and the back.
// ----------------------------------------------------------------------------
module jsu_queue
  import jsu_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  job_t      wr_job,
  input  wire logic take,
  output job_t      rd_job,
  output logic      full,
  output logic      avail
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_take;

  assign full    = (count == CNT_W'(DEPTH));
  assign avail   = (count != '0);
  assign do_push = push && !full;
  assign do_take = take && avail;
  assign rd_job  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_take) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_take})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/jsu_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_back
// Expands the job at the head of the queue into one to three result items
// and holds each in the output register until it is popped.
// ----------------------------------------------------------------------------
module jsu_back
  import jsu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  job_t            job,
  input  wire logic       job_avail,
  output logic            job_take,
  input  wire logic       pop,
  output logic            empty,
  output logic [7:0]      out_byte,
  output logic            byte_valid,
  output logic [2:0]      status,
  output logic            last_of_run
);

  logic       out_full;
  logic [1:0] idx;
  logic [1:0] n_items;
  logic       load;
  logic       item_last;
  logic [7:0] item_byte;
  logic [5:0] cp_lo, cp_mid;

  assign empty = !out_full;
  assign load  = job_avail && (!out_full || pop);

  assign cp_lo  = job.data[5:0];
  assign cp_mid = job.data[11:6];

  always_comb begin
    if (!job.valid || !job.is_cp || job.data < CP_ONE_MAX) begin
      n_items = 2'd1;
    end else if (job.data < CP_TWO_MAX) begin
      n_items = 2'd2;
    end else begin
      n_items = 2'd3;
    end
    item_last = (idx == n_items - 2'd1);
    item_byte = job.data[7:0];
    case (n_items)
      2'd2: item_byte = (idx == 2'd0) ? (UTF8_LEAD2 | {3'b000, job.data[10:6]})
                                      : (UTF8_CONT | ({2'b00, cp_lo} & UTF8_MASK));
      2'd3: begin
        case (idx)
          2'd0:    item_byte = UTF8_LEAD3 | {4'h0, job.data[15:12]};
          2'd1:    item_byte = UTF8_CONT | ({2'b00, cp_mid} & UTF8_MASK);
          default: item_byte = UTF8_CONT | ({2'b00, cp_lo} & UTF8_MASK);
        endcase
      end
      default: item_byte = job.valid ? job.data[7:0] : 8'h00;
    endcase
  end

  assign job_take = load && item_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
      idx      <= '0;
    end else begin
      if (load) begin
        out_full <= 1'b1;
        idx      <= item_last ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        out_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= item_byte;
      byte_valid  <= job.valid;
      status      <= job.status;
      last_of_run <= item_last;
    end
  end

endmodule

`default_nettype wire

### design/jsu_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level checks on the result channel of the unescaper.
// ----------------------------------------------------------------------------
module jsu_checker
  import jsu_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       empty,
  input wire logic [7:0] out_byte,
  input wire logic       byte_valid,
  input wire logic [2:0] status
);

  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // a status flag never carries a byte, and always ends its run
  a_flag_no_byte: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != ST_CONT) |-> (!byte_valid && out_byte == 8'h00))
    else $error("flagged item carries a byte");

  a_no_byte_needs_flag: assert property (@(posedge clk) disable iff (rst)
    (!empty && !byte_valid) |-> (status != ST_CONT))
    else $error("item with no byte and no status");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (status == ST_CONT || status == ST_CLOSED || status == ST_BADESC ||
                status == ST_BADHEX || status == ST_UNTERM))
    else $error("status code out of range");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
  .clk        (clk),
  .rst        (rst),
  .empty      (empty),
  .out_byte   (out_byte),
  .byte_valid (byte_valid),
  .status     (status)
);

`default_nettype wire

### dv/jsu_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_result_checker
// Watches both queue ports of the JSON string unescaper, decodes every
// accepted input byte on its own copy of the decode state and compares each
// popped result, field by field, with the oldest decoded byte still owed.
// ----------------------------------------------------------------------------
module jsu_result_checker
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] in_byte,
  input  logic       text_ends,
  input  logic       empty,
  input  logic       pop,
  input  logic [7:0] out_byte,
  input  logic       byte_valid,
  input  logic [2:0] status,
  input  logic       last_of_run,
  output int         fail_count,
  output int         outstanding
);

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    status_t    st;
    logic       last;
  } decoded_t;

  decoded_t    decoded_q[$];
  mode_t       mode     = MODE_NORMAL;
  logic [1:0]  digits   = 2'd0;
  logic [15:0] cp_acc   = 16'd0;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic owe(input logic [7:0] b, input logic v, input status_t st,
                     input logic last);
    decoded_t item;
    item = '{data: b, valid: v, st: st, last: last};
    decoded_q.insert(decoded_q.size(), item);
  endtask

  task automatic back_to_normal();
    mode   = MODE_NORMAL;
    digits = 2'd0;
    cp_acc = 16'd0;
  endtask

  // 5th bit flags a byte that is no hex digit
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c inside {[8'h30:8'h39]}) return {1'b0, c[3:0]};
    if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) return {1'b0, c[3:0] + 4'd9};
    return 5'h10;
  endfunction

  task automatic owe_utf8(input logic [15:0] cp);
    if (cp < CP_ONE_MAX) begin
      owe(cp[7:0], 1'b1, ST_CONT, 1'b1);
    end else if (cp < CP_TWO_MAX) begin
      owe(UTF8_LEAD2 | 8'(cp >> 6), 1'b1, ST_CONT, 1'b0);
      owe(UTF8_CONT | (cp[7:0] & UTF8_MASK), 1'b1, ST_CONT, 1'b1);
    end else begin
      owe(UTF8_LEAD3 | 8'(cp >> 12), 1'b1, ST_CONT, 1'b0);
      owe(UTF8_CONT | (8'(cp >> 6) & UTF8_MASK), 1'b1, ST_CONT, 1'b0);
      owe(UTF8_CONT | (cp[7:0] & UTF8_MASK), 1'b1, ST_CONT, 1'b1);
    end
  endtask

  task automatic decode_input(input logic [7:0] c, input logic ends);
    logic [4:0]  nib;
    logic [15:0] cp;
    if (ends) begin
      back_to_normal();
      owe(8'h00, 1'b0, ST_UNTERM, 1'b1);
      return;
    end
    case (mode)
      MODE_ESCAPE: begin
        back_to_normal();
        case (c)
          CHR_QUOTE, CHR_BSLASH, CHR_SLASH: owe(c, 1'b1, ST_CONT, 1'b1);
          "b": owe(8'h08, 1'b1, ST_CONT, 1'b1);
          "f": owe(8'h0C, 1'b1, ST_CONT, 1'b1);
          "n": owe(8'h0A, 1'b1, ST_CONT, 1'b1);
          "r": owe(8'h0D, 1'b1, ST_CONT, 1'b1);
          "t": owe(8'h09, 1'b1, ST_CONT, 1'b1);
          CHR_U: mode = MODE_HEX;
          default: owe(8'h00, 1'b0, ST_BADESC, 1'b1);
        endcase
      end
      MODE_HEX: begin
        nib = nibble_of(c);
        if (nib[4]) begin
          back_to_normal();
          owe(8'h00, 1'b0, ST_BADHEX, 1'b1);
        end else begin
          cp = {cp_acc[11:0], nib[3:0]};
          if (digits == 2'd3) begin
            back_to_normal();
            owe_utf8(cp);
          end else begin
            cp_acc = cp;
            digits = digits + 2'd1;
          end
        end
      end
      default: begin
        if (c == CHR_QUOTE) begin
          back_to_normal();
          owe(8'h00, 1'b0, ST_CLOSED, 1'b1);
        end else if (c == CHR_BSLASH) begin
          mode = MODE_ESCAPE;
        end else begin
          owe(c, 1'b1, ST_CONT, 1'b1);
        end
      end
    endcase
  endtask

  // results first: nothing popped at an edge can stem from a byte pushed at it
  always @(posedge clk) begin
    decoded_t exp_item;
    if (rst) begin
      back_to_normal();
      decoded_q.delete();
    end else begin
      if (pop && !empty) begin
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("result 0x%02h with nothing expected", out_byte));
        end else begin
          exp_item = decoded_q.pop_front();
          if (out_byte !== exp_item.data)
            report_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h",
                                      out_byte, exp_item.data));
          if (byte_valid !== exp_item.valid)
            report_mismatch($sformatf("byte_valid %b, expected %b",
                                      byte_valid, exp_item.valid));
          if (status !== exp_item.st)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      status, exp_item.st));
          if (last_of_run !== exp_item.last)
            report_mismatch($sformatf("last_of_run %b, expected %b",
                                      last_of_run, exp_item.last));
        end
      end
      if (push && !full) decode_input(in_byte, text_ends);
    end
    outstanding = decoded_q.size();
  end

endmodule

### dv/tb_json_string_unescape_utf8.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_json_string_unescape_utf8
// Feeds string bodies to the unescaper: a short directed set of edge cases,
// then random fragments (plain bytes, escapes, \u sequences, quotes, broken
// escapes, end of text) under several idle/stall mixes and one long
// receiver hold-off. Checking is done in jsu_result_checker.
// ----------------------------------------------------------------------------
module tb_json_string_unescape_utf8
  import jsu_pkg::*;
();

  localparam int HOLD_CYCLES = 60;
  localparam int PHASE_BYTES = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       ends;
  } text_item_t;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [7:0] in_byte;
  logic       text_ends;
  logic       empty;
  logic       pop;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic [2:0] status;
  logic       last_of_run;
  int         fail_count;
  int         outstanding;

  text_item_t stim_q[$];
  int         recv_stall_pct = 0;
  logic       hold_req       = 1'b0;
  int         hold_left      = 0;
  logic [7:0] esc_letters[8] = '{CHR_QUOTE, CHR_BSLASH, CHR_SLASH,
                                 "b", "f", "n", "r", "t"};

  json_string_unescape_utf8 dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .in_byte     (in_byte),
    .text_ends   (text_ends),
    .empty       (empty),
    .pop         (pop),
    .out_byte    (out_byte),
    .byte_valid  (byte_valid),
    .status      (status),
    .last_of_run (last_of_run)
  );

  jsu_result_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .in_byte     (in_byte),
    .text_ends   (text_ends),
    .empty       (empty),
    .pop         (pop),
    .out_byte    (out_byte),
    .byte_valid  (byte_valid),
    .status      (status),
    .last_of_run (last_of_run),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [7:0] hex_char(input logic [3:0] n, input logic upper);
    if (n < 4'd10) return 8'h30 + {4'h0, n};
    return (upper ? 8'h41 : 8'h61) + {4'h0, n} - 8'd10;
  endfunction

  task automatic queue_item(input logic [7:0] b, input logic ends);
    text_item_t s;
    s = '{data: b, ends: ends};
    stim_q.insert(stim_q.size(), s);
  endtask

  task automatic queue_unicode(input logic [15:0] cp);
    queue_item(CHR_BSLASH, 1'b0);
    queue_item(CHR_U, 1'b0);
    for (int i = 3; i >= 0; i--)
      queue_item(hex_char(cp[i*4 +: 4], 1'($urandom_range(1))), 1'b0);
  endtask

  // one random piece of string body, mostly well formed
  task automatic queue_fragment();
    int         kind;
    int         n;
    logic [7:0] b;
    logic [15:0] cp;
    kind = $urandom_range(99);
    if (kind < 40) begin
      do b = 8'($urandom_range(255)); while (b == CHR_QUOTE || b == CHR_BSLASH);
      queue_item(b, 1'b0);
    end else if (kind < 55) begin
      queue_item(CHR_BSLASH, 1'b0);
      queue_item(esc_letters[$urandom_range(7)], 1'b0);
    end else if (kind < 75) begin
      case ($urandom_range(2))
        0:       cp = 16'($urandom_range(16'h007F));
        1:       cp = 16'($urandom_range(16'h07FF, 16'h0080));
        default: cp = 16'($urandom_range(16'hFFFF, 16'h0800));
      endcase
      queue_unicode(cp);
    end else if (kind < 83) begin
      queue_item(CHR_QUOTE, 1'b0);
    end else if (kind < 88) begin
      queue_item(CHR_BSLASH, 1'b0);
      queue_item(8'($urandom_range(255)), 1'b0);
    end else if (kind < 93) begin
      // \u cut short by a non-hex byte
      queue_item(CHR_BSLASH, 1'b0);
      queue_item(CHR_U, 1'b0);
      n = $urandom_range(3);
      repeat (n) queue_item(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))),
                            1'b0);
      b = $urandom_range(1) ? 8'(8'h47 + $urandom_range(19)) : 8'($urandom_range(8'h2F));
      queue_item(b, 1'b0);
    end else if (kind < 97) begin
      // end of text, sometimes inside an escape
      n = $urandom_range(2);
      if (n > 0) queue_item(CHR_BSLASH, 1'b0);
      if (n > 1) begin
        queue_item(CHR_U, 1'b0);
        repeat ($urandom_range(3)) queue_item(hex_char(4'($urandom_range(15)), 1'b1), 1'b0);
      end
      queue_item(8'($urandom_range(255)), 1'b1);
    end else begin
      queue_item(8'($urandom_range(255)), 1'b0);
    end
  endtask

  task automatic send_queued(input int idle_pct);
    text_item_t s;
    while (stim_q.size() > 0) begin
      s = stim_q.pop_front();
      while ($urandom_range(99) < idle_pct) begin
        push    <= 1'b0;
        in_byte <= 8'($urandom_range(255));
        @(posedge clk);
      end
      push      <= 1'b1;
      in_byte   <= s.data;
      text_ends <= s.ends;
      @(posedge clk);
      while (full) @(posedge clk);
    end
    push <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random_phase(input int send_idle_pct, input int stall_pct);
    recv_stall_pct = stall_pct;
    while (stim_q.size() < PHASE_BYTES) queue_fragment();
    send_queued(send_idle_pct);
  endtask

  // receiver: random stalls, plus a counted hold-off on request
  initial begin
    pop = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst       = 1'b1;
    push      = 1'b0;
    in_byte   = 8'h00;
    text_ends = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed edge cases
    queue_item(8'h00, 1'b0);
    queue_item(8'hFF, 1'b0);
    queue_item(CHR_BSLASH, 1'b0);
    queue_item("n", 1'b0);
    queue_unicode(16'h0000);
    queue_unicode(16'hFFFF);
    queue_item(CHR_BSLASH, 1'b0);
    queue_item("q", 1'b0);
    queue_item(CHR_BSLASH, 1'b0);
    queue_item(CHR_U, 1'b0);
    queue_item("1", 1'b0);
    queue_item("G", 1'b0);
    queue_item(CHR_QUOTE, 1'b0);
    queue_item(8'h5A, 1'b1);
    send_queued(0);

    // back-to-back input while the receiver holds off: fills the queue
    hold_req = 1'b1;
    run_random_phase(0, 0);
    run_random_phase(52, 0);
    run_random_phase(0, 52);
    run_random_phase(30, 30);

    recv_stall_pct = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
